/* hw/rtl/egbp_pkg.sv */
`default_nettype none

package egbp_pkg;

  // fixed field widths of the channels and the default value width
  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned DefValueBits = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ZERO,
    ST_DATA,
    ST_FLUSH
  } egbp_state_e;

  // leading zeros of one byte, 7 for an all-zero byte
  function automatic logic [2:0] lead_zeros8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/egbp_if.sv */
`default_nettype none

interface egbp_in_if import egbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  logic                  end_of_block;

  modport source (output valid, output value, output end_of_block, input ready);
  modport sink   (input valid, input value, input end_of_block, output ready);
endinterface

interface egbp_out_if import egbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] out_byte;
  logic                 run_last;
  logic                 padded_flush;

  modport source (output valid, output out_byte, output run_last, output padded_flush,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input padded_flush,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/egbp_merge.sv */
`default_nettype none

// appends up to eight code bits to the pending bits and cuts off a full byte
module egbp_merge import egbp_pkg::*; (
  input  logic [ByteWidth-1:0] pend_i,
  input  logic [2:0]           cnt_i,
  input  logic [ByteWidth-1:0] chunk_i,
  input  logic [3:0]           nbits_i,
  output logic [ByteWidth-1:0] byte_o,
  output logic                 full_o,
  output logic [ByteWidth-1:0] pend_o,
  output logic [2:0]           cnt_o
);

  logic [2*ByteWidth-1:0] joined;
  logic [3:0]             total;

  assign joined = {{ByteWidth{1'b0}}, pend_i} | ({{ByteWidth{1'b0}}, chunk_i} << cnt_i);
  assign total  = {1'b0, cnt_i} + nbits_i;

  assign full_o = total[3];
  assign byte_o = joined[ByteWidth-1:0];
  assign pend_o = total[3] ? joined[2*ByteWidth-1:ByteWidth] : joined[ByteWidth-1:0];
  assign cnt_o  = total[2:0];

endmodule

`default_nettype wire

/* hw/rtl/elias_gamma_bit_packer.sv */
`default_nettype none

// channel  dir  modport  payload
// in_i     in   sink     value[63:0], end_of_block
// out_o    out  source   out_byte[7:0], run_last, padded_flush
//
// one item at a time: it is taken while idle, then a leading-zero search one byte
// per cycle, then the zero prefix and the value bits eight per cycle unless a
// held output beat stalls them, then an optional flush beat when the end of the
// block leaves pending bits.
// reset clears the state machine, the pending bits and the output valid flag.
// a held output beat stalls the emit phases; a new item is taken only when idle.
module elias_gamma_bit_packer import egbp_pkg::*; #(
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  egbp_in_if.sink           in_i,
  egbp_out_if.source        out_o
);

  localparam int unsigned XW = VALUE_BITS + 1;
  localparam int unsigned NB = (XW + 7) / 8;
  localparam int unsigned PW = NB * 8;
  localparam int unsigned DW = $clog2(NB + 1);
  localparam int unsigned KW = $clog2(XW + 1);
  localparam int unsigned RW = $clog2(2 * XW + 8);

  egbp_state_e state_q, state_d;

  logic [PW-1:0]        x_q, x_d;
  logic [DW-1:0]        dcnt_q, dcnt_d;
  logic [KW-1:0]        zr_q, zr_d;
  logic [KW-1:0]        dr_q, dr_d;
  logic [ByteWidth-1:0] pend_q, pend_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 eob_q, eob_d;

  logic                 out_valid_q;
  logic [ByteWidth-1:0] out_byte_q;
  logic                 out_last_q;
  logic                 out_pad_q;

  logic                 in_acc;
  logic                 slot_free;
  logic [XW-1:0]        x_sum;
  logic [7:0]           top_byte;
  logic                 top_zero;
  logic [2:0]           lz;
  logic [KW-1:0]        k_val;
  logic [3:0]           z_bits;
  logic [3:0]           m_bits;
  logic [KW-1:0]        zr_rest;
  logic [KW-1:0]        dr_rest;
  logic [ByteWidth-1:0] chunk_data;
  logic [ByteWidth-1:0] mrg_chunk;
  logic [3:0]           mrg_nbits;
  logic [ByteWidth-1:0] mrg_byte;
  logic                 mrg_full;
  logic [ByteWidth-1:0] mrg_pend;
  logic [2:0]           mrg_cnt;
  logic [RW-1:0]        fut_zero;
  logic [RW-1:0]        fut_data;

  logic                 emit;
  logic [ByteWidth-1:0] emit_byte;
  logic                 emit_last;
  logic                 emit_pad;

  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // successor in one extra bit, so the all-ones value becomes a single high bit
  assign x_sum = {1'b0, in_i.value[VALUE_BITS-1:0]} + XW'(1);

  assign top_byte = x_q[PW-1 -: 8];
  assign top_zero = (top_byte == 8'd0);
  assign lz       = lead_zeros8(top_byte);
  assign k_val    = KW'({dcnt_q, 3'b000} - {{DW{1'b0}}, lz});

  assign z_bits  = (zr_q >= KW'(8)) ? 4'd8 : zr_q[3:0];
  assign m_bits  = (dr_q >= KW'(8)) ? 4'd8 : dr_q[3:0];
  assign zr_rest = zr_q - KW'(z_bits);
  assign dr_rest = dr_q - KW'(m_bits);

  // value bits leave msb first, earliest into bit 0
  always_comb begin
    chunk_data = '0;
    for (int j = 0; j < 8; j++) begin
      chunk_data[j] = x_q[PW-1-j] & (4'(j) < m_bits);
    end
  end

  assign mrg_chunk = (state_q == ST_DATA) ? chunk_data : '0;
  assign mrg_nbits = (state_q == ST_DATA) ? m_bits : z_bits;

  egbp_merge u_merge (
    .pend_i  (pend_q),
    .cnt_i   (cnt_q),
    .chunk_i (mrg_chunk),
    .nbits_i (mrg_nbits),
    .byte_o  (mrg_byte),
    .full_o  (mrg_full),
    .pend_o  (mrg_pend),
    .cnt_o   (mrg_cnt)
  );

  // bits still to come for this item decide whether this beat is its last
  assign fut_zero = RW'(mrg_cnt) + RW'(zr_rest) + RW'(dr_q);
  assign fut_data = RW'(mrg_cnt) + RW'(dr_rest);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!(top_zero && dcnt_q > DW'(1))) begin
          state_d = (k_val == KW'(1)) ? ST_DATA : ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (slot_free && zr_rest == '0) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (slot_free && dr_rest == '0) begin
          state_d = (eob_q && mrg_cnt != 3'd0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and beat generation
  always_comb begin
    x_d       = x_q;
    dcnt_d    = dcnt_q;
    zr_d      = zr_q;
    dr_d      = dr_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    eob_d     = eob_q;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_pad  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d    = PW'(x_sum);
          dcnt_d = DW'(NB);
          eob_d  = in_i.end_of_block;
        end
      end
      ST_SEARCH: begin
        if (top_zero && dcnt_q > DW'(1)) begin
          x_d    = x_q << 8;
          dcnt_d = dcnt_q - DW'(1);
        end else begin
          x_d  = x_q << lz;
          zr_d = k_val - KW'(1);
          dr_d = k_val;
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          zr_d      = zr_rest;
          pend_d    = mrg_pend;
          cnt_d     = mrg_cnt;
          emit      = mrg_full;
          emit_byte = mrg_byte;
          emit_last = (fut_zero < RW'(8)) && !eob_q;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          x_d       = x_q << 8;
          dr_d      = dr_rest;
          pend_d    = mrg_pend;
          cnt_d     = mrg_cnt;
          emit      = mrg_full;
          emit_byte = mrg_byte;
          emit_last = (fut_data < RW'(8)) && !(eob_q && fut_data != '0);
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = pend_q;
          emit_last = 1'b1;
          emit_pad  = 1'b1;
          pend_d    = '0;
          cnt_d     = 3'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    dcnt_q <= dcnt_d;
    zr_q   <= zr_d;
    dr_q   <= dr_d;
    eob_q  <= eob_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_pad_q  <= emit_pad;
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.run_last     = out_last_q;
  assign out_o.padded_flush = out_pad_q;

endmodule

`default_nettype wire
